[rtl/i2c_master_bit_engine_assert.svh]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_assert
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");

// Next-cycle implication, disabled during reset.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");

`endif

[rtl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, widths and helpers for the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int unsigned TicksW  = 16;
  localparam int unsigned PhaseW  = 5;
  localparam int unsigned InDataW = 16;
  localparam int unsigned InUserW = 4;
  localparam int unsigned OutW    = 16;

  localparam logic [TicksW-1:0] TicksReset = 16'd30;

  // Output word bit positions
  localparam int unsigned OutScl    = 0;
  localparam int unsigned OutSda    = 1;
  localparam int unsigned OutBusy   = 2;
  localparam int unsigned OutDone   = 3;
  localparam int unsigned OutRxLo   = 4;
  localparam int unsigned OutAck    = 12;
  localparam int unsigned OutRefuse = 13;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_STOP    = 3'd1,
    OP_WRITE   = 3'd2,
    OP_READ    = 3'd3,
    OP_WAITACK = 3'd4,
    OP_ACK     = 3'd5,
    OP_NACK    = 3'd6
  } op_e;

  function automatic logic [PhaseW-1:0] phase_count(op_e cmd);
    logic [PhaseW-1:0] n;
    case (cmd)
      OP_STOP:  n = 5'd1;
      OP_WRITE: n = 5'd24;
      OP_READ:  n = 5'd16;
      default:  n = 5'd3;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Open-drain I2C master line sequencer, one tick per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on s_axis is one tick: an optional command (start, stop, write
//   byte, read byte, wait ack, send ack, send nack) and the sampled SDA pin.
//   Each accepted tick yields exactly one word on m_axis with the SCL/SDA
//   drive, busy, done, last read byte, ack result and a refusal flag.
//   cfg_data_i sets the ticks each line phase is held; write it with no word in flight.
// Throughput:
//   One tick per clock while m_axis is not stalled. The result word appears in the
//   cycle after the tick is accepted, held in a single output register; the sequencer
//   state and that register both update on the accepting edge.
// Stall:
//   s_axis_tready is high while the output register is empty or being taken,
//   so a stalled receiver stops ticks after one buffered word; no word lost.
// Reset:
//   Lines released high, idle, counters and read byte cleared, phase length
//   back to 30 ticks, output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [i2cm_pkg::TicksW-1:0]      cfg_data_i,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] write_data, [8] sda_in, [15:9] zero
  input  wire  [i2cm_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] cmd_valid, [3:1] opcode
  input  wire  [i2cm_pkg::InUserW-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [0] scl_line, [1] sda_line, [2] busy_res, [3] done_res,
  // [11:4] read_byte, [12] ack_received, [13] cmd_refused, [15:14] zero
  output logic [i2cm_pkg::OutW-1:0]        m_axis_tdata
);

  logic                          cmd_valid;
  logic [2:0]                    opcode;
  logic [7:0]                    wdata;
  logic                          sda_in;
  logic                          in_acc;

  logic [i2cm_pkg::TicksW-1:0]   cfg_q;
  logic                          scl_q, scl_d, sda_q, sda_d, busy_q, busy_d;
  i2cm_pkg::op_e                 cmd_q, cmd_d;
  logic [i2cm_pkg::PhaseW-1:0]   phase_q, phase_d, phase_nx;
  logic [1:0]                    sub_q, sub_d;
  logic [2:0]                    bit_q, bit_d;
  logic [7:0]                    shift_q, shift_d, rx_q, rx_d;
  logic [i2cm_pkg::TicksW-1:0]   tick_q, tick_d;
  logic                          ack_q, ack_d;
  logic                          done, refused, enter;
  logic                          ovld_q;
  logic [i2cm_pkg::OutW-1:0]     odata_q;

  assign cmd_valid = s_axis_tuser[0];
  assign opcode    = s_axis_tuser[3:1];
  assign wdata     = s_axis_tdata[7:0];
  assign sda_in    = s_axis_tdata[8];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !ovld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  always_comb begin
    scl_d    = scl_q;
    sda_d    = sda_q;
    busy_d   = busy_q;
    cmd_d    = cmd_q;
    phase_d  = phase_q;
    sub_d    = sub_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    rx_d     = rx_q;
    tick_d   = tick_q;
    ack_d    = ack_q;
    done     = 1'b0;
    refused  = 1'b0;
    enter    = 1'b0;
    phase_nx = 5'(phase_q + 5'd1);

    if (busy_q) begin
      refused = cmd_valid;
      if (tick_q >= cfg_q) begin
        if (cmd_q == i2cm_pkg::OP_READ && !phase_q[0]) begin
          shift_d = {shift_q[6:0], sda_in};
        end else if (cmd_q == i2cm_pkg::OP_WAITACK && phase_q == 5'd1) begin
          ack_d = ~sda_in;
        end
        if (phase_nx >= i2cm_pkg::phase_count(cmd_q)) begin
          if (cmd_q == i2cm_pkg::OP_STOP || cmd_q == i2cm_pkg::OP_ACK) begin
            sda_d = 1'b1;
          end
          if (cmd_q == i2cm_pkg::OP_READ) begin
            rx_d = shift_d;
          end
          busy_d  = 1'b0;
          done    = 1'b1;
          tick_d  = '0;
          phase_d = '0;
        end else begin
          phase_d = phase_nx;
          if (sub_q == 2'd2) begin
            sub_d = 2'd0;
            bit_d = 3'(bit_q + 3'd1);
          end else begin
            sub_d = 2'(sub_q + 2'd1);
          end
          enter  = 1'b1;
          tick_d = 16'd1;
        end
      end else begin
        tick_d = 16'(tick_q + 16'd1);
      end
    end else if (cmd_valid && opcode <= 3'(i2cm_pkg::OP_NACK)) begin
      cmd_d   = i2cm_pkg::op_e'(opcode);
      busy_d  = 1'b1;
      phase_d = '0;
      sub_d   = 2'd0;
      bit_d   = 3'd0;
      shift_d = (opcode == 3'(i2cm_pkg::OP_WRITE)) ? wdata : 8'd0;
      enter   = 1'b1;
      tick_d  = 16'd1;
    end

    if (enter) begin
      case (cmd_d)
        i2cm_pkg::OP_START: begin
          if (phase_d == 5'd0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else if (phase_d == 5'd1) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        i2cm_pkg::OP_STOP: begin
          sda_d = 1'b0;
          scl_d = 1'b1;
        end
        i2cm_pkg::OP_WRITE: begin
          if (sub_d == 2'd0) begin
            sda_d = shift_d[7];
          end else if (sub_d == 2'd1) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
            if (bit_d == 3'd7) sda_d = 1'b1;
            shift_d = {shift_d[6:0], 1'b0};
          end
        end
        i2cm_pkg::OP_READ: begin
          scl_d = ~phase_d[0];
        end
        default: begin
          if (phase_d == 5'd0) begin
            sda_d = (cmd_d == i2cm_pkg::OP_ACK) ? 1'b0 : 1'b1;
          end else if (phase_d == 5'd1) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= i2cm_pkg::TicksReset;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      busy_q  <= 1'b0;
      cmd_q   <= i2cm_pkg::OP_START;
      phase_q <= '0;
      sub_q   <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      rx_q    <= 8'd0;
      tick_q  <= '0;
      ack_q   <= 1'b0;
    end else if (in_acc) begin
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      busy_q  <= busy_d;
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
      tick_q  <= tick_d;
      ack_q   <= ack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (in_acc) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      odata_q <= {2'b00, refused, ack_d, rx_d, done, busy_d, sda_d, scl_d};
    end
  end

endmodule

`default_nettype wire

[rtl/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level assertions for the I2C master bit engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_engine_assert.svh"

module i2cm_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire [i2cm_pkg::InUserW-1:0]  s_axis_tuser,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [i2cm_pkg::OutW-1:0]     m_axis_tdata
);

  logic o_done, o_busy, o_refused;

  assign o_done    = m_axis_tdata[i2cm_pkg::OutDone];
  assign o_busy    = m_axis_tdata[i2cm_pkg::OutBusy];
  assign o_refused = m_axis_tdata[i2cm_pkg::OutRefuse];

  // stalled result word holds
  `I2CM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

  // empty output register never blocks input
  `I2CM_ASSERT_NOW(a_in_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // a finishing tick leaves the engine idle
  `I2CM_ASSERT_NOW(a_done_idle, clk_i, rst_ni, m_axis_tvalid && o_done, !o_busy)

  // refusal only happens while a command runs
  `I2CM_ASSERT_NOW(a_refuse_busy, clk_i, rst_ni, m_axis_tvalid && o_refused,
                   o_busy || o_done)

  // a tick without a command is never refused
  `I2CM_ASSERT_NEXT(a_refuse_cmd, clk_i, rst_ni,
                    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0],
                    m_axis_tvalid && !o_refused)

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire

[sim/tb_i2c_master_bit_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine
// Self-checking bench for the I2C master bit engine.
// ----------------------------------------------------------------------------
// Every tick word sent on s_axis is run through a local model of the line
// sequencer, and the word it predicts (or a typed row's own word) is queued.
// Every word taken from m_axis is checked field by field against the oldest
// queued word. A short table of directed ticks comes first. Random I2C
// transactions follow under several phase lengths, with noise, refused
// commands, random stalls on both sides, and one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_i2c_master_bit_engine;

  localparam logic [2:0] OpUnused   = 3'd7;
  localparam int         NumDir     = 30;
  localparam int         NumPhases  = 6;
  localparam int         TicksPerPh = 100;
  localparam int         HoldCycles = 300;
  localparam int         TailCycles = 20;
  localparam int         StallLimit = 2000;

  typedef struct packed {
    logic [1:0] pad;
    logic       refused;
    logic       ack;
    logic [7:0] rx;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } result_t;

  typedef struct packed {
    logic                        is_cfg;
    logic [i2cm_pkg::TicksW-1:0] cfg_val;
    logic                        v;
    logic [2:0]                  op;
    logic [7:0]                  wd;
    logic                        sda;
    logic [4:0]                  reps;
    logic                        typed;
    result_t                     exp;
  } step_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [i2cm_pkg::TicksW-1:0]   cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [i2cm_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [i2cm_pkg::InUserW-1:0]  s_axis_tuser  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [i2cm_pkg::OutW-1:0]     m_axis_tdata;

  // model state
  logic                        line_scl  = 1'b1;
  logic                        line_sda  = 1'b1;
  logic                        seq_busy  = 1'b0;
  logic [2:0]                  seq_cmd   = i2cm_pkg::OP_START;
  logic [4:0]                  seq_phase = '0;
  logic [7:0]                  shift_q   = '0;
  logic [7:0]                  rx_byte   = '0;
  logic                        ack_q     = 1'b0;
  logic [i2cm_pkg::TicksW-1:0] hold_cnt  = '0;
  logic [i2cm_pkg::TicksW-1:0] phase_len = i2cm_pkg::TicksReset;

  result_t line_words_due [$];
  result_t got, want, pred;
  logic    typed_on  = 1'b0;
  result_t typed_exp = '0;
  bit      idle_en   = 1'b1;
  bit      hold_req  = 1'b0;
  int      err_cnt   = 0;
  int      word_idx  = 0;
  int      stall_cycles;

  i2c_master_bit_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t word(logic scl, logic sda, logic busy, logic done,
                                   logic [7:0] rx, logic ack, logic refused);
    result_t w;
    w = '0;
    w.scl     = scl;
    w.sda     = sda;
    w.busy    = busy;
    w.done    = done;
    w.rx      = rx;
    w.ack     = ack;
    w.refused = refused;
    return w;
  endfunction

  function automatic string fmt_word(result_t w);
    return $sformatf("scl=%b sda=%b busy=%b done=%b rx=%h ack=%b ref=%b",
                     w.scl, w.sda, w.busy, w.done, w.rx, w.ack, w.refused);
  endfunction

  function automatic void note_error(string what);
    if (err_cnt < 10) begin
      $display("ERROR: %s", what);
    end
    err_cnt++;
  endfunction

  function automatic void enter_phase(logic [4:0] p);
    case (seq_cmd)
      i2cm_pkg::OP_START: begin
        if (p == 5'd0) begin
          line_sda = 1'b1;
          line_scl = 1'b1;
        end else if (p == 5'd1) begin
          line_sda = 1'b0;
        end else begin
          line_scl = 1'b0;
        end
      end
      i2cm_pkg::OP_STOP: begin
        line_sda = 1'b0;
        line_scl = 1'b1;
      end
      i2cm_pkg::OP_WRITE: begin
        case (p % 3)
          0: line_sda = shift_q[7];
          1: line_scl = 1'b1;
          default: begin
            line_scl = 1'b0;
            if (p / 3 == 7) line_sda = 1'b1;
            shift_q = {shift_q[6:0], 1'b0};
          end
        endcase
      end
      i2cm_pkg::OP_READ: line_scl = ~p[0];
      default: begin
        if (p == 5'd0) begin
          line_sda = (seq_cmd != i2cm_pkg::OP_ACK);
        end else if (p == 5'd1) begin
          line_scl = 1'b1;
        end else begin
          line_scl = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic result_t step_engine(logic v, logic [2:0] op, logic [7:0] wd,
                                          logic sda);
    result_t    r;
    logic [4:0] n_phases;
    r = '0;
    if (seq_busy) begin
      r.refused = v;
      if (hold_cnt >= phase_len) begin
        if (seq_cmd == i2cm_pkg::OP_READ && !seq_phase[0]) begin
          shift_q = {shift_q[6:0], sda};
        end else if (seq_cmd == i2cm_pkg::OP_WAITACK && seq_phase == 5'd1) begin
          ack_q = ~sda;
        end
        seq_phase = seq_phase + 5'd1;
        case (seq_cmd)
          i2cm_pkg::OP_STOP:  n_phases = 5'd1;
          i2cm_pkg::OP_WRITE: n_phases = 5'd24;
          i2cm_pkg::OP_READ:  n_phases = 5'd16;
          default:            n_phases = 5'd3;
        endcase
        if (seq_phase >= n_phases) begin
          if (seq_cmd == i2cm_pkg::OP_STOP || seq_cmd == i2cm_pkg::OP_ACK) line_sda = 1'b1;
          if (seq_cmd == i2cm_pkg::OP_READ) rx_byte = shift_q;
          seq_busy  = 1'b0;
          r.done    = 1'b1;
          hold_cnt  = '0;
          seq_phase = '0;
        end else begin
          enter_phase(seq_phase);
          hold_cnt = 16'd1;
        end
      end else begin
        hold_cnt = hold_cnt + 1'b1;
      end
    end else if (v && op != OpUnused) begin
      seq_cmd   = op;
      seq_busy  = 1'b1;
      seq_phase = '0;
      shift_q   = (op == i2cm_pkg::OP_WRITE) ? wd : 8'd0;
      enter_phase(5'd0);
      hold_cnt  = 16'd1;
    end
    r.scl  = line_scl;
    r.sda  = line_sda;
    r.busy = seq_busy;
    r.rx   = rx_byte;
    r.ack  = ack_q;
    return r;
  endfunction

  function automatic step_t cfg_row(logic [i2cm_pkg::TicksW-1:0] val);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.cfg_val = val;
    return s;
  endfunction

  function automatic step_t tick_row(logic v, logic [2:0] op, logic [7:0] wd,
                                     logic sda, logic [4:0] reps);
    step_t s;
    s = '0;
    s.v    = v;
    s.op   = op;
    s.wd   = wd;
    s.sda  = sda;
    s.reps = reps;
    return s;
  endfunction

  function automatic step_t typed_row(logic v, logic [2:0] op, result_t exp);
    step_t s;
    s = tick_row(v, op, 8'h00, 1'b0, 5'd1);
    s.typed = 1'b1;
    s.exp   = exp;
    return s;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (line_words_due.size() == 0) begin
          note_error($sformatf("word %0d with nothing expected: %s", word_idx,
                               fmt_word(got)));
        end else begin
          want = line_words_due.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
              got.done !== want.done || got.rx !== want.rx || got.ack !== want.ack ||
              got.refused !== want.refused || got.pad !== want.pad) begin
            note_error($sformatf("word %0d exp %s got %s", word_idx, fmt_word(want),
                                 fmt_word(got)));
          end
        end
        word_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pred = step_engine(s_axis_tuser[0], s_axis_tuser[3:1], s_axis_tdata[7:0],
                           s_axis_tdata[8]);
        line_words_due.push_back(typed_on ? typed_exp : pred);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        phase_len = cfg_data_i;
      end
    end
  end

  // receiver side
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input logic v, input logic [2:0] op, input logic [7:0] wd,
                           input logic sda, input logic typed, input result_t exp);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    typed_on  = typed;
    typed_exp = exp;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {op, v};
    s_axis_tdata  <= {7'd0, sda, wd};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (line_words_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_phase_len(input logic [i2cm_pkg::TicksW-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    step_t                       dir_tab [NumDir];
    step_t                       row;
    logic [2:0]                  plan_q [$];
    logic [i2cm_pkg::TicksW-1:0] ptab [NumPhases];
    logic                        v;
    logic [2:0]                  op;
    int                          i;
    int                          n;
    int                          ph;

    dir_tab = '{
      cfg_row(16'd1),
      typed_row(1'b0, i2cm_pkg::OP_START, word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)),
      typed_row(1'b1, OpUnused,           word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)),
      typed_row(1'b1, i2cm_pkg::OP_START, word(1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)),
      typed_row(1'b1, i2cm_pkg::OP_STOP,  word(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1)),
      tick_row(1'b0, i2cm_pkg::OP_START, 8'h00, 1'b0, 5'd1),
      // command on the finishing tick is refused
      typed_row(1'b1, OpUnused,           word(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1)),
      tick_row(1'b1, i2cm_pkg::OP_WRITE,   8'hFF, 1'b1, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b1, 5'd24),
      tick_row(1'b1, i2cm_pkg::OP_WAITACK, 8'h00, 1'b0, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b0, 5'd3),
      tick_row(1'b1, i2cm_pkg::OP_READ,    8'h00, 1'b1, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b1, 5'd16),
      tick_row(1'b1, i2cm_pkg::OP_ACK,     8'h00, 1'b0, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b0, 5'd3),
      tick_row(1'b1, i2cm_pkg::OP_WAITACK, 8'h00, 1'b1, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b1, 5'd3),
      tick_row(1'b1, i2cm_pkg::OP_WRITE,   8'h00, 1'b0, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b0, 5'd24),
      tick_row(1'b1, i2cm_pkg::OP_READ,    8'h00, 1'b0, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b0, 5'd16),
      tick_row(1'b1, i2cm_pkg::OP_NACK,    8'h00, 1'b1, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b1, 5'd3),
      tick_row(1'b1, i2cm_pkg::OP_STOP,    8'h00, 1'b0, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b0, 5'd1),
      cfg_row(16'hFFFF),
      tick_row(1'b1, i2cm_pkg::OP_START,   8'h00, 1'b0, 5'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b0, 5'd5),
      // shorten the phase while it is running
      cfg_row(16'd1),
      tick_row(1'b0, i2cm_pkg::OP_START,   8'h00, 1'b0, 5'd4)
    };
    ptab = '{16'd2, 16'd0, 16'd1, 16'd3, 16'd5, 16'd1};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < NumDir; i++) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        write_phase_len(row.cfg_val);
      end else begin
        for (n = 0; n < row.reps; n++) begin
          send_tick(row.v, row.op, row.wd, row.sda, row.typed, row.exp);
        end
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      write_phase_len((ph == NumPhases - 1) ? 16'($urandom_range(0, 4)) : ptab[ph]);
      idle_en = (ph != NumPhases - 1);
      if (ph == 2) hold_req = 1'b1;
      for (n = 0; n < TicksPerPh; n++) begin
        op = 3'($urandom_range(0, 7));
        if (seq_busy) begin
          v = ($urandom_range(0, 9) == 0);
        end else if (plan_q.size() == 0) begin
          v = 1'b0;
          if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) plan_q.push_back(3'($urandom_range(0, 7)));
          end else begin
            plan_q.push_back(i2cm_pkg::OP_START);
            plan_q.push_back(i2cm_pkg::OP_WRITE);
            plan_q.push_back(i2cm_pkg::OP_WAITACK);
            repeat ($urandom_range(1, 3)) begin
              if ($urandom_range(0, 1) == 0) begin
                plan_q.push_back(i2cm_pkg::OP_WRITE);
                plan_q.push_back(i2cm_pkg::OP_WAITACK);
              end else begin
                plan_q.push_back(i2cm_pkg::OP_READ);
                plan_q.push_back(($urandom_range(0, 1) == 0) ? i2cm_pkg::OP_ACK
                                                             : i2cm_pkg::OP_NACK);
              end
            end
            plan_q.push_back(i2cm_pkg::OP_STOP);
          end
        end else if ($urandom_range(0, 3) == 0) begin
          v = 1'b0;
        end else begin
          v  = 1'b1;
          op = plan_q.pop_front();
        end
        send_tick(v, op, 8'($urandom), 1'($urandom), 1'b0, '0);
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (line_words_due.size() != 0) begin
      note_error($sformatf("%0d expected words never arrived", line_words_due.size()));
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
